### hdl/tpfa_pkg.sv
// ----------------------------------------------------------------------------
// tpfa_pkg: shared types and constants of the trail point FIFO
// Command codes, register indexes, sequencer states and datapath widths.
// ----------------------------------------------------------------------------
package tpfa_pkg;

	// Item fields
	localparam int CMD_W   = 2;
	localparam int COORD_W = 24;
	localparam int MAG_W   = COORD_W + 1;
	localparam int DELTA_W = 20;
	localparam int AGE_W   = 32;
	localparam int SEG_W   = 23;

	// Shared multiplier: magnitude times 32-bit factor
	localparam int PROD_W  = MAG_W + AGE_W;
	localparam int ACC_W   = 2 * MAG_W + 1;
	localparam int DIV_STEPS = PROD_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam logic [CFG_IDX_W-1:0] CFG_LIFETIME = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT  = 2'd1;

	// Reset values
	localparam int POINT_DEPTH_DEF = 64;
	localparam logic [AGE_W-1:0] LIFETIME_RST = 32'd1000000;
	localparam logic [SEG_W-1:0] SEGMENT_RST  = 23'd2560;
	localparam logic [AGE_W-1:0] GAP_RST      = 32'd1000000;
	localparam logic [ACC_W-1:0] ONE_PIXEL_SQ = ACC_W'(65536);

	// Commands
	localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_START = 2'd1;
	localparam logic [CMD_W-1:0] CMD_STOP  = 2'd2;

	typedef enum logic [4:0] {
		S_IDLE,
		S_DEC,
		S_STOP_RD,
		S_STOP_CHK,
		S_D_X,
		S_D_Y,
		S_D_SUM,
		S_D_CMP,
		S_PUSH,
		S_A_INIT,
		S_A_RD,
		S_A_WR,
		S_A_DONE,
		S_T_START,
		S_T_RD1,
		S_T_CAP1,
		S_T_PREP,
		S_T_MUL,
		S_T_DIV,
		S_T_FIN,
		S_OUT
	} state_t;

	// What a distance check is for
	typedef enum logic [1:0] {
		P_TICK,
		P_STOP,
		P_TAIL
	} purp_t;

	// Sign and magnitude of a - b on 24-bit signed coordinates
	function automatic logic [MAG_W:0] abs_diff(input logic [COORD_W-1:0] a,
			input logic [COORD_W-1:0] b);
		logic [MAG_W-1:0] d;
		d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
		abs_diff = d[MAG_W-1] ? {1'b1, MAG_W'(-d)} : {1'b0, d};
	endfunction

endpackage

### hdl/trail_point_fifo_aging_top.sv
// With two or more points held, the tail adds two 57-step bit-serial divisions
// (none with a zero age gap), and a tick adds the age walk, which reads and
// rewrites each held point in turn. Throughput: one item at a time, the next
// word taken once the result sits in the output register. Asynchronous reset
// clears control state at once; the point memory holds no reset and needs no
// clearing pass.
// ----------------------------------------------------------------------------
// trail_point_fifo_aging_top: timestamped trail point FIFO with aging
// Appends emitter points, ages and expires them and reports a shrinking tail,
// all through one multiplier and one divider under a small sequencer.
// ----------------------------------------------------------------------------
module trail_point_fifo_aging_top #(
	parameter int POINT_DEPTH = tpfa_pkg::POINT_DEPTH_DEF,
	localparam int AW = $clog2(POINT_DEPTH),
	localparam int CW = $clog2(POINT_DEPTH + 1)
) (
	input  logic clk,
	input  logic arst_n,
	// input channel
	input  logic in_valid,
	output logic in_ready,
	input  logic [tpfa_pkg::CMD_W-1:0] cmd,
	input  logic signed [tpfa_pkg::COORD_W-1:0] pos_x,
	input  logic signed [tpfa_pkg::COORD_W-1:0] pos_y,
	input  logic [tpfa_pkg::DELTA_W-1:0] delta_us,
	// result channel
	output logic out_valid,
	input  logic out_ready,
	output logic [CW-1:0] point_count,
	output logic finished,
	output logic running,
	output logic tail_valid,
	output logic signed [tpfa_pkg::COORD_W-1:0] tail_x,
	output logic signed [tpfa_pkg::COORD_W-1:0] tail_y,
	output logic overflow,
	// configuration channel
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [tpfa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tpfa_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int XW = tpfa_pkg::COORD_W;
	localparam int MW = tpfa_pkg::MAG_W;
	localparam int GW = tpfa_pkg::AGE_W;
	localparam int PW = tpfa_pkg::PROD_W;
	localparam int QW = tpfa_pkg::ACC_W;
	localparam int SW = CW + 1;

	tpfa_pkg::state_t state_q, state_d;
	tpfa_pkg::purp_t  purp_q;

	// configuration and persistent state
	logic [GW-1:0] lifetime_q;
	logic [tpfa_pkg::SEG_W-1:0] seg_q;
	logic [AW-1:0] head_q;
	logic [CW-1:0] fill_q;
	logic [XW-1:0] spawn_x_q, spawn_y_q;
	logic [GW-1:0] gap_q;
	logic emit_q, active_q, run_q;

	// current item
	logic [tpfa_pkg::CMD_W-1:0] cmd_q;
	logic [XW-1:0] px_q, py_q;
	logic [tpfa_pkg::DELTA_W-1:0] delta_q;
	logic fin_q, ovf_q, gapupd_q;

	// age walk
	logic [CW-1:0] i_q, exp_q;
	logic still_q;
	logic [AW-1:0] addr_q;

	// distance unit
	logic [MW-1:0] opx_q, opy_q;
	logic [PW-1:0] prod_q;
	logic [QW-1:0] acc_q;

	// tail
	logic [GW-1:0] age0_q, n_q;
	logic [XW-1:0] x0_q, y0_q, nx_q, ny_q, tx_q, ty_q;
	logic sgnx_q, sgny_q, axis_q, tvalid_q;
	logic [MW-1:0] magx_q, magy_q, qx_q, qy_q, quo_q;
	logic [PW-1:0] dvd_q;
	logic [GW-1:0] rem_q;
	logic [tpfa_pkg::DIV_CNT_W-1:0] cnt_q;

	// point memory
	logic [XW-1:0] x_mem [POINT_DEPTH];
	logic [XW-1:0] y_mem [POINT_DEPTH];
	logic [GW-1:0] age_mem [POINT_DEPTH];
	logic [XW-1:0] rd_x_q, rd_y_q;
	logic [GW-1:0] rd_age_q;
	logic [AW-1:0] rd_addr, wr_addr;
	logic wr_xy_en, wr_age_en;
	logic [GW-1:0] wr_age;

	// output register
	logic out_valid_q;
	logic [CW-1:0] cnt_out_q;
	logic fin_out_q, run_out_q, tv_out_q, ovf_out_q;
	logic [XW-1:0] tx_out_q, ty_out_q;

	// shared combinational pieces
	logic [MW-1:0] mul_a;
	logic [GW-1:0] mul_b;
	logic [PW-1:0] mul_p;
	logic [GW:0] age_sum;
	logic [GW-1:0] age_new;
	logic [GW:0] rem_sh;
	logic rem_ge;
	logic [MW-1:0] quo_next;
	logic dist_gt;
	logic [CW-1:0] fill_left;
	logic fifo_full;
	logic [GW-1:0] num_c, n_c;
	logic [MW:0] dx_c, dy_c;

	// ring slot of the k-th oldest point
	function automatic logic [AW-1:0] slot(input logic [AW-1:0] head,
			input logic [CW-1:0] k);
		logic [SW-1:0] s;
		s = SW'(head) + SW'(k);
		if (s >= SW'(POINT_DEPTH)) begin
			s = s - SW'(POINT_DEPTH);
		end
		slot = s[AW-1:0];
	endfunction

	assign in_ready  = (state_q == tpfa_pkg::S_IDLE);
	assign cfg_ready = 1'b1;

	assign out_valid   = out_valid_q;
	assign point_count = cnt_out_q;
	assign finished    = fin_out_q;
	assign running     = run_out_q;
	assign tail_valid  = tv_out_q;
	assign tail_x      = tx_out_q;
	assign tail_y      = ty_out_q;
	assign overflow    = ovf_out_q;

	// shared multiplier operand select
	always_comb begin
		mul_a = opx_q;
		mul_b = GW'(opx_q);
		case (state_q)
			tpfa_pkg::S_D_Y: begin
				mul_a = opy_q;
				mul_b = GW'(opy_q);
			end
			tpfa_pkg::S_D_SUM: begin
				mul_a = MW'(seg_q);
				mul_b = GW'(seg_q);
			end
			tpfa_pkg::S_T_MUL: begin
				mul_a = axis_q ? magy_q : magx_q;
				mul_b = n_q;
			end
			default: begin
			end
		endcase
	end
	assign mul_p = PW'(mul_a) * PW'(mul_b);

	// saturating age add, divider step, compare
	assign age_sum  = {1'b0, rd_age_q} + (GW + 1)'(delta_q);
	assign age_new  = age_sum[GW] ? {GW{1'b1}} : age_sum[GW-1:0];
	assign rem_sh   = {rem_q, dvd_q[PW-1]};
	assign rem_ge   = (rem_sh >= {1'b0, gap_q});
	assign quo_next = {quo_q[MW-2:0], rem_ge};
	assign dist_gt  = (purp_q == tpfa_pkg::P_TICK) ? (PW'(acc_q) > prod_q)
		: (acc_q > tpfa_pkg::ONE_PIXEL_SQ);
	assign fill_left = fill_q - exp_q;
	assign fifo_full = (fill_q == CW'(POINT_DEPTH));
	assign num_c = (lifetime_q > age0_q) ? (lifetime_q - age0_q) : '0;
	assign n_c   = (num_c < gap_q) ? num_c : gap_q;
	assign dx_c  = tpfa_pkg::abs_diff(x0_q, nx_q);
	assign dy_c  = tpfa_pkg::abs_diff(y0_q, ny_q);

	// next state and memory control
	always_comb begin
		state_d   = state_q;
		rd_addr   = head_q;
		wr_addr   = addr_q;
		wr_xy_en  = 1'b0;
		wr_age_en = 1'b0;
		wr_age    = age_new;
		case (state_q)
			tpfa_pkg::S_IDLE: begin
				if (in_valid) begin
					state_d = tpfa_pkg::S_DEC;
				end
			end
			tpfa_pkg::S_DEC: begin
				state_d = tpfa_pkg::S_T_START;
				if (cmd_q == tpfa_pkg::CMD_STOP && emit_q && fill_q != '0) begin
					state_d = tpfa_pkg::S_STOP_RD;
				end else if (cmd_q == tpfa_pkg::CMD_TICK && run_q) begin
					if (!emit_q) begin
						state_d = tpfa_pkg::S_A_INIT;
					end else if (fill_q == '0) begin
						state_d = tpfa_pkg::S_PUSH;
					end else begin
						state_d = tpfa_pkg::S_D_X;
					end
				end
			end
			tpfa_pkg::S_STOP_RD: begin
				rd_addr = slot(head_q, fill_q - CW'(1));
				state_d = tpfa_pkg::S_STOP_CHK;
			end
			tpfa_pkg::S_STOP_CHK: state_d = tpfa_pkg::S_D_X;
			tpfa_pkg::S_D_X:      state_d = tpfa_pkg::S_D_Y;
			tpfa_pkg::S_D_Y:      state_d = tpfa_pkg::S_D_SUM;
			tpfa_pkg::S_D_SUM:    state_d = tpfa_pkg::S_D_CMP;
			tpfa_pkg::S_D_CMP: begin
				case (purp_q)
					tpfa_pkg::P_TICK:
						state_d = dist_gt ? tpfa_pkg::S_PUSH : tpfa_pkg::S_A_INIT;
					tpfa_pkg::P_STOP:
						state_d = dist_gt ? tpfa_pkg::S_PUSH : tpfa_pkg::S_T_START;
					default: state_d = tpfa_pkg::S_OUT;
				endcase
			end
			tpfa_pkg::S_PUSH: begin
				wr_xy_en  = 1'b1;
				wr_age_en = 1'b1;
				wr_age    = '0;
				wr_addr   = fifo_full ? head_q : slot(head_q, fill_q);
				state_d   = (cmd_q == tpfa_pkg::CMD_TICK) ? tpfa_pkg::S_A_INIT
					: tpfa_pkg::S_T_START;
			end
			tpfa_pkg::S_A_INIT: state_d = tpfa_pkg::S_A_RD;
			tpfa_pkg::S_A_RD: begin
				rd_addr = slot(head_q, i_q);
				state_d = (i_q == fill_q) ? tpfa_pkg::S_A_DONE : tpfa_pkg::S_A_WR;
			end
			tpfa_pkg::S_A_WR: begin
				wr_age_en = 1'b1;
				state_d   = tpfa_pkg::S_A_RD;
			end
			tpfa_pkg::S_A_DONE: state_d = tpfa_pkg::S_T_START;
			tpfa_pkg::S_T_START: begin
				rd_addr = head_q;
				state_d = (fill_q < CW'(2)) ? tpfa_pkg::S_OUT : tpfa_pkg::S_T_RD1;
			end
			tpfa_pkg::S_T_RD1: begin
				rd_addr = slot(head_q, CW'(1));
				state_d = tpfa_pkg::S_T_CAP1;
			end
			tpfa_pkg::S_T_CAP1: state_d = tpfa_pkg::S_T_PREP;
			tpfa_pkg::S_T_PREP: begin
				state_d = (gap_q == '0) ? tpfa_pkg::S_T_FIN : tpfa_pkg::S_T_MUL;
			end
			tpfa_pkg::S_T_MUL: state_d = tpfa_pkg::S_T_DIV;
			tpfa_pkg::S_T_DIV: begin
				if (cnt_q == tpfa_pkg::DIV_CNT_W'(tpfa_pkg::DIV_STEPS - 1)) begin
					state_d = axis_q ? tpfa_pkg::S_T_FIN : tpfa_pkg::S_T_MUL;
				end
			end
			tpfa_pkg::S_T_FIN: state_d = tpfa_pkg::S_D_X;
			tpfa_pkg::S_OUT: begin
				if (!out_valid_q || out_ready) begin
					state_d = tpfa_pkg::S_IDLE;
				end
			end
			default: state_d = tpfa_pkg::S_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tpfa_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// point memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_xy_en) begin
			x_mem[wr_addr] <= px_q;
			y_mem[wr_addr] <= py_q;
		end
		if (wr_age_en) begin
			age_mem[wr_addr] <= wr_age;
		end
		rd_x_q   <= x_mem[rd_addr];
		rd_y_q   <= y_mem[rd_addr];
		rd_age_q <= age_mem[rd_addr];
	end

	// control state, configuration and output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lifetime_q  <= tpfa_pkg::LIFETIME_RST;
			seg_q       <= tpfa_pkg::SEGMENT_RST;
			head_q      <= '0;
			fill_q      <= '0;
			spawn_x_q   <= '0;
			spawn_y_q   <= '0;
			gap_q       <= tpfa_pkg::GAP_RST;
			emit_q      <= 1'b1;
			active_q    <= 1'b1;
			run_q       <= 1'b1;
			purp_q      <= tpfa_pkg::P_TICK;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == tpfa_pkg::CFG_LIFETIME) begin
					lifetime_q <= cfg_data;
				end else if (cfg_index == tpfa_pkg::CFG_SEGMENT) begin
					seg_q <= cfg_data[tpfa_pkg::SEG_W-1:0];
				end
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				tpfa_pkg::S_DEC: begin
					if (cmd_q == tpfa_pkg::CMD_START && !emit_q) begin
						emit_q    <= 1'b1;
						fill_q    <= '0;
						head_q    <= '0;
						active_q  <= 1'b1;
						run_q     <= 1'b1;
						spawn_x_q <= px_q;
						spawn_y_q <= py_q;
						gap_q     <= tpfa_pkg::GAP_RST;
					end else if (cmd_q == tpfa_pkg::CMD_STOP && emit_q) begin
						emit_q <= 1'b0;
						purp_q <= tpfa_pkg::P_STOP;
					end else if (cmd_q == tpfa_pkg::CMD_TICK && run_q) begin
						if (!emit_q && !active_q) begin
							run_q <= 1'b0;
						end
						purp_q <= tpfa_pkg::P_TICK;
						if (emit_q && fill_q == '0) begin
							spawn_x_q <= px_q;
							spawn_y_q <= py_q;
						end
					end
				end
				tpfa_pkg::S_D_CMP: begin
					if (purp_q == tpfa_pkg::P_TICK && dist_gt) begin
						spawn_x_q <= px_q;
						spawn_y_q <= py_q;
					end
				end
				tpfa_pkg::S_PUSH: begin
					if (fifo_full) begin
						head_q <= slot(head_q, CW'(1));
					end else begin
						fill_q <= fill_q + CW'(1);
					end
				end
				tpfa_pkg::S_A_DONE: begin
					if (exp_q != '0) begin
						head_q <= slot(head_q, exp_q);
						fill_q <= fill_left;
					end
					if (fill_left == '0) begin
						head_q <= '0;
						gap_q  <= tpfa_pkg::GAP_RST;
						if (!emit_q) begin
							active_q <= 1'b0;
						end
					end
				end
				tpfa_pkg::S_T_CAP1: begin
					if (gapupd_q) begin
						gap_q <= age0_q - rd_age_q;
					end
				end
				tpfa_pkg::S_T_FIN: purp_q <= tpfa_pkg::P_TAIL;
				tpfa_pkg::S_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// item datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			tpfa_pkg::S_IDLE: begin
				cmd_q    <= cmd;
				px_q     <= pos_x;
				py_q     <= pos_y;
				delta_q  <= delta_us;
				fin_q    <= 1'b0;
				ovf_q    <= 1'b0;
				gapupd_q <= 1'b0;
				tvalid_q <= 1'b0;
				tx_q     <= '0;
				ty_q     <= '0;
			end
			tpfa_pkg::S_DEC: begin
				opx_q <= MW'(tpfa_pkg::abs_diff(spawn_x_q, px_q));
				opy_q <= MW'(tpfa_pkg::abs_diff(spawn_y_q, py_q));
			end
			tpfa_pkg::S_STOP_CHK: begin
				opx_q <= MW'(tpfa_pkg::abs_diff(px_q, rd_x_q));
				opy_q <= MW'(tpfa_pkg::abs_diff(py_q, rd_y_q));
			end
			// squared distance: dx*dx, dy*dy, sum, threshold
			tpfa_pkg::S_D_X: prod_q <= mul_p;
			tpfa_pkg::S_D_Y: begin
				acc_q  <= QW'(prod_q);
				prod_q <= mul_p;
			end
			tpfa_pkg::S_D_SUM: begin
				acc_q  <= acc_q + QW'(prod_q);
				prod_q <= mul_p;
			end
			tpfa_pkg::S_D_CMP: begin
				if (purp_q == tpfa_pkg::P_TAIL) begin
					tvalid_q <= dist_gt;
				end
			end
			tpfa_pkg::S_PUSH: begin
				if (fifo_full) begin
					ovf_q <= 1'b1;
				end
			end
			// age walk with running expiry count
			tpfa_pkg::S_A_INIT: begin
				i_q     <= '0;
				exp_q   <= '0;
				still_q <= 1'b1;
			end
			tpfa_pkg::S_A_RD: addr_q <= slot(head_q, i_q);
			tpfa_pkg::S_A_WR: begin
				i_q <= i_q + CW'(1);
				if (still_q && age_new > lifetime_q) begin
					exp_q <= exp_q + CW'(1);
				end else begin
					still_q <= 1'b0;
				end
			end
			tpfa_pkg::S_A_DONE: begin
				if (exp_q != '0 && fill_left >= CW'(2)) begin
					gapupd_q <= 1'b1;
				end
				if (fill_left == '0) begin
					fin_q <= 1'b1;
				end
			end
			// tail: oldest and second oldest points
			tpfa_pkg::S_T_RD1: begin
				x0_q   <= rd_x_q;
				y0_q   <= rd_y_q;
				age0_q <= rd_age_q;
			end
			tpfa_pkg::S_T_CAP1: begin
				nx_q <= rd_x_q;
				ny_q <= rd_y_q;
			end
			tpfa_pkg::S_T_PREP: begin
				n_q    <= n_c;
				sgnx_q <= dx_c[MW];
				sgny_q <= dy_c[MW];
				magx_q <= dx_c[MW-1:0];
				magy_q <= dy_c[MW-1:0];
				axis_q <= 1'b0;
				qx_q   <= (num_c != '0) ? dx_c[MW-1:0] : '0;
				qy_q   <= (num_c != '0) ? dy_c[MW-1:0] : '0;
			end
			tpfa_pkg::S_T_MUL: begin
				dvd_q <= mul_p;
				rem_q <= '0;
				quo_q <= '0;
				cnt_q <= '0;
			end
			// restoring division, one quotient bit a cycle
			tpfa_pkg::S_T_DIV: begin
				rem_q <= rem_ge ? GW'(rem_sh - {1'b0, gap_q}) : rem_sh[GW-1:0];
				dvd_q <= {dvd_q[PW-2:0], 1'b0};
				quo_q <= quo_next;
				cnt_q <= cnt_q + tpfa_pkg::DIV_CNT_W'(1);
				if (cnt_q == tpfa_pkg::DIV_CNT_W'(tpfa_pkg::DIV_STEPS - 1)) begin
					if (axis_q) begin
						qy_q <= quo_next;
					end else begin
						qx_q   <= quo_next;
						axis_q <= 1'b1;
					end
				end
			end
			tpfa_pkg::S_T_FIN: begin
				tx_q  <= sgnx_q ? (nx_q - qx_q[XW-1:0]) : (nx_q + qx_q[XW-1:0]);
				ty_q  <= sgny_q ? (ny_q - qy_q[XW-1:0]) : (ny_q + qy_q[XW-1:0]);
				opx_q <= qx_q;
				opy_q <= qy_q;
			end
			tpfa_pkg::S_OUT: begin
				if (!out_valid_q || out_ready) begin
					cnt_out_q <= fill_q;
					fin_out_q <= fin_q;
					run_out_q <= run_q;
					tv_out_q  <= tvalid_q;
					tx_out_q  <= tx_q;
					ty_out_q  <= ty_q;
					ovf_out_q <= ovf_q;
				end
			end
			default: begin
			end
		endcase
	end

`ifndef SYNTHESIS
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(POINT_DEPTH))
		else $error("fill count beyond depth");
	a_tail_needs_two: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && tail_valid |-> point_count >= CW'(2))
		else $error("tail reported with fewer than two points");
	a_finished_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && finished |-> point_count == '0)
		else $error("finished with points left");
	a_busy_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == tpfa_pkg::S_A_WR |=> !in_ready)
		else $error("input taken during the age walk");
`endif

endmodule

### verif/trail_point_fifo_aging_top_tb.sv
// ----------------------------------------------------------------------------
// trail_point_fifo_aging_top_tb: self-checking bench of the trail point FIFO
// Drives start, stop, tick and unknown words over valid/ready, predicts every
// result word with a local copy of the FIFO state and compares field by field.
// ----------------------------------------------------------------------------
module trail_point_fifo_aging_top_tb;

	localparam int DEPTH = tpfa_pkg::POINT_DEPTH_DEF;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [tpfa_pkg::CMD_W-1:0] CMD_NONE = 2'd3;

	typedef struct packed {
		logic [CW-1:0] count;
		logic fin;
		logic run;
		logic tvalid;
		logic [23:0] tx;
		logic [23:0] ty;
		logic ovf;
	} trail_status_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [tpfa_pkg::CMD_W-1:0] cmd = tpfa_pkg::CMD_TICK;
	logic signed [23:0] pos_x = '0;
	logic signed [23:0] pos_y = '0;
	logic [19:0] delta_us = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [CW-1:0] point_count;
	logic finished, running, tail_valid, overflow;
	logic signed [23:0] tail_x, tail_y;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [tpfa_pkg::CFG_IDX_W-1:0] cfg_index = tpfa_pkg::CFG_LIFETIME;
	logic [tpfa_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	trail_point_fifo_aging_top #(.POINT_DEPTH(DEPTH)) DUT (.*);

	always #2 clk = ~clk;

	// trail state mirror
	logic [31:0] life_us, seg_len;
	longint trail_x[DEPTH], trail_y[DEPTH];
	logic [31:0] trail_age[DEPTH];
	int head, fill;
	longint spawn_x, spawn_y;
	logic [31:0] age_gap;
	bit emitting, active, run_flag;

	trail_status_t status_q[$];
	int errors = 0, n_words = 0, n_results = 0, n_ovf = 0, n_fin = 0;
	bit quiet = 0;

	function automatic longint dsq(longint ax, longint ay, longint bx, longint by);
		return (ax - bx) * (ax - bx) + (ay - by) * (ay - by);
	endfunction

	function automatic int slot_of(int k);
		return (head + k) % DEPTH;
	endfunction

	function automatic bit append_point(longint x, longint y);
		bit dropped = 0;
		int s;
		if (fill >= DEPTH) begin
			head = (head + 1) % DEPTH;
			fill = DEPTH - 1;
			dropped = 1;
		end
		s = slot_of(fill);
		trail_x[s] = x;
		trail_y[s] = y;
		trail_age[s] = 32'd0;
		fill++;
		return dropped;
	endfunction

	function automatic longint shrink_axis(longint from, longint to, longint n, longint gap);
		longint d, q;
		d = to - from;
		q = ((d < 0) ? -d : d) * n / gap;
		return (d < 0) ? from - q : from + q;
	endfunction

	function automatic void reset_trail();
		life_us = tpfa_pkg::LIFETIME_RST;
		seg_len = 32'(tpfa_pkg::SEGMENT_RST);
		head = 0; fill = 0; spawn_x = 0; spawn_y = 0;
		age_gap = tpfa_pkg::GAP_RST;
		emitting = 1; active = 1; run_flag = 1;
	endfunction

	// next status word of the trail for one input word
	function automatic trail_status_t predict_trail(logic [1:0] c, longint px, longint py,
			longint dt);
		trail_status_t r;
		int expired, s0, s1;
		longint a, num, n, tx, ty;
		r = '0;
		tx = 0; ty = 0;
		if (c == tpfa_pkg::CMD_START) begin
			if (!emitting) begin
				emitting = 1; fill = 0; head = 0; active = 1; run_flag = 1;
				spawn_x = px; spawn_y = py; age_gap = tpfa_pkg::GAP_RST;
			end
		end else if (c == tpfa_pkg::CMD_STOP) begin
			if (emitting) begin
				emitting = 0;
				if (fill > 0) begin
					s0 = slot_of(fill - 1);
					if (dsq(px, py, trail_x[s0], trail_y[s0]) > 65536)
						r.ovf = append_point(px, py);
				end
			end
		end else if (c == tpfa_pkg::CMD_TICK && run_flag) begin
			if (emitting && (fill == 0 ||
					dsq(spawn_x, spawn_y, px, py) > longint'(seg_len) * seg_len)) begin
				spawn_x = px; spawn_y = py;
				r.ovf = append_point(px, py);
			end
			if (!emitting && !active) run_flag = 0;
			for (int i = 0; i < fill; i++) begin
				a = longint'(trail_age[slot_of(i)]) + dt;
				trail_age[slot_of(i)] = (a > 64'hFFFFFFFF) ? 32'hFFFFFFFF : a[31:0];
			end
			expired = 0;
			while (expired < fill && trail_age[slot_of(expired)] > life_us) expired++;
			if (expired > 0) begin
				head = slot_of(expired);
				fill -= expired;
				if (fill >= 2) age_gap = trail_age[slot_of(0)] - trail_age[slot_of(1)];
			end
			if (fill == 0) begin
				head = 0; age_gap = tpfa_pkg::GAP_RST; r.fin = 1;
				if (!emitting) active = 0;
			end
		end
		if (fill >= 2) begin
			s0 = slot_of(0); s1 = slot_of(1);
			num = (life_us > trail_age[s0]) ? longint'(life_us) - trail_age[s0] : 0;
			if (age_gap == 0) begin
				tx = (num > 0) ? trail_x[s0] : trail_x[s1];
				ty = (num > 0) ? trail_y[s0] : trail_y[s1];
			end else begin
				n = (num < age_gap) ? num : age_gap;
				tx = shrink_axis(trail_x[s1], trail_x[s0], n, age_gap);
				ty = shrink_axis(trail_y[s1], trail_y[s0], n, age_gap);
			end
			r.tvalid = dsq(tx, ty, trail_x[s1], trail_y[s1]) > 65536;
		end
		r.count = CW'(fill);
		r.run = run_flag;
		r.tx = tx[23:0];
		r.ty = ty[23:0];
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		errors++;
		$display("mismatch word %0d %s: got %0h want %0h", n_results, what, got, want);
	endtask

	// random backpressure on results
	always @(posedge clk) begin
		if (!arst_n) out_ready <= 1'b0;
		else out_ready <= quiet || ($urandom_range(99) >= 7);
	end

	// result checker
	always @(posedge clk) begin
		trail_status_t w;
		if (arst_n && out_valid && out_ready) begin
			if (status_q.size() == 0) report_mismatch("unexpected", 1, 0);
			else begin
				w = status_q.pop_front();
				if (point_count !== w.count) report_mismatch("point_count", point_count, w.count);
				if (finished !== w.fin) report_mismatch("finished", finished, w.fin);
				if (running !== w.run) report_mismatch("running", running, w.run);
				if (tail_valid !== w.tvalid) report_mismatch("tail_valid", tail_valid, w.tvalid);
				if (tail_x !== w.tx) report_mismatch("tail_x", tail_x, w.tx);
				if (tail_y !== w.ty) report_mismatch("tail_y", tail_y, w.ty);
				if (overflow !== w.ovf) report_mismatch("overflow", overflow, w.ovf);
				if (w.ovf) n_ovf++;
				if (w.fin) n_fin++;
			end
			n_results++;
		end
	end

	// the block stays busy after a word, so the task first waits on the clock
	task automatic send_word(logic [1:0] c, logic [23:0] x, logic [23:0] y, logic [19:0] dt);
		@(posedge clk);
		while (!quiet && $urandom_range(99) < 7) @(posedge clk);
		status_q.insert(status_q.size(), predict_trail(c, $signed(x), $signed(y), dt));
		cmd <= c; pos_x <= x; pos_y <= y; delta_us <= dt; in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		in_valid <= 1'b0;
		n_words++;
	endtask

	task automatic drain();
		while (status_q.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(logic [tpfa_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
		drain();
		cfg_index <= idx; cfg_data <= val; cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == tpfa_pkg::CFG_LIFETIME) life_us = val;
		else seg_len = 32'(val[22:0]);
	endtask

	// extremes, all commands and special cases
	task automatic test_directed();
		send_word(tpfa_pkg::CMD_TICK, 24'h7FFFFF, 24'h800000, 20'd1000);
		send_word(tpfa_pkg::CMD_TICK, 24'h800000, 24'h7FFFFF, 20'hFFFFF);
		send_word(tpfa_pkg::CMD_TICK, 24'h000000, 24'h000000, 20'd0);
		send_word(CMD_NONE, 24'h123456, 24'h654321, 20'd5);
		send_word(tpfa_pkg::CMD_START, 24'd5, 24'd5, 20'd0);
		send_word(tpfa_pkg::CMD_STOP, 24'd9000, 24'd0, 20'd0);
		send_word(tpfa_pkg::CMD_STOP, 24'd0, 24'd0, 20'd0);
		send_word(tpfa_pkg::CMD_START, 24'd100, 24'd100, 20'd0);
		send_word(tpfa_pkg::CMD_TICK, 24'd100, 24'd100, 20'd100);
		send_word(tpfa_pkg::CMD_TICK, 24'd100, 24'd100, 20'd100);
		send_word(tpfa_pkg::CMD_STOP, 24'd200, 24'd100, 20'd0);
		repeat (12) send_word(tpfa_pkg::CMD_TICK, 24'd0, 24'd0, 20'hFFFFF);
		send_word(tpfa_pkg::CMD_START, 24'd0, 24'd0, 20'd0);
	endtask

	// fill past depth with a tiny segment so the oldest point is dropped
	task automatic test_overflow();
		write_reg(tpfa_pkg::CFG_SEGMENT, 32'd1);
		write_reg(tpfa_pkg::CFG_LIFETIME, 32'hFFFFFFFF);
		for (int i = 0; i < 80; i++)
			send_word(tpfa_pkg::CMD_TICK, 24'(i * 300), 24'(-i * 77), 20'hFFFFF);
		repeat (20) send_word(tpfa_pkg::CMD_TICK, 24'd0, 24'd0, 20'hFFFFF);
		send_word(tpfa_pkg::CMD_STOP, 24'd0, 24'd0, 20'd0);
		send_word(tpfa_pkg::CMD_START, 24'd0, 24'd0, 20'd0);
	endtask

	// emission sessions with random motion under several register settings
	task automatic test_random(int words, logic [31:0] life, logic [31:0] seg, int dmax);
		longint x, y;
		int r;
		write_reg(tpfa_pkg::CFG_LIFETIME, life);
		write_reg(tpfa_pkg::CFG_SEGMENT, seg);
		x = 0; y = 0;
		for (int i = 0; i < words; i++) begin
			r = $urandom_range(99);
			x += $signed(24'($urandom_range(8000))) - 4000;
			y += $signed(24'($urandom_range(8000))) - 4000;
			if (r < 4) send_word(tpfa_pkg::CMD_START, x[23:0], y[23:0], 20'($urandom));
			else if (r < 8) send_word(tpfa_pkg::CMD_STOP, x[23:0], y[23:0], 20'($urandom));
			else if (r < 10) send_word(CMD_NONE, 24'($urandom), 24'($urandom), 20'($urandom));
			else if (r < 13)
				send_word(tpfa_pkg::CMD_TICK, 24'($urandom), 24'($urandom), 20'($urandom));
			else send_word(tpfa_pkg::CMD_TICK, x[23:0], y[23:0], 20'($urandom_range(dmax)));
		end
		send_word(tpfa_pkg::CMD_START, 24'd0, 24'd0, 20'd0);
	endtask

	initial begin
		reset_trail();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(250, tpfa_pkg::LIFETIME_RST, 32'(tpfa_pkg::SEGMENT_RST), 40000);
		quiet = 1;
		test_random(150, 32'd200000, 32'd300, 20000);
		quiet = 0;
		test_random(250, 32'd1, 32'h7FFFFF, 3);
		test_random(300, 32'd50000, 32'd0, 5000);
		test_random(100, 32'd0, 32'd1000, 10);
		test_overflow();
		test_random(300, 32'd3000000, 32'd2000, 60000);
		drain();
		$display("covered %0d input words, %0d results, %0d overflows, %0d finished ticks",
			n_words, n_results, n_ovf, n_fin);
		if (errors == 0) $display("TEST PASSED");
		else $display("TEST FAILED");
		$finish;
	end

	initial begin
		#10000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

### sim.f
hdl/tpfa_pkg.sv
hdl/trail_point_fifo_aging_top.sv
verif/trail_point_fifo_aging_top_tb.sv
